// ===== hdl/mexp_pkg.sv =====
// Shared types, constants and the control store of the modular exponentiation block.
// The control store is a constant table indexed by the step counter.
// No dependencies.
`default_nettype none

package mexp_pkg;

  localparam int FIELD_W     = 62;
  localparam int IN_TDATA_W  = 192;
  localparam int OUT_TDATA_W = 64;
  localparam int PC_W        = 4;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t STEP_IDLE     = 4'd0;
  localparam pc_t STEP_CHK_EXP  = 4'd1;
  localparam pc_t STEP_CHK_MOD  = 4'd2;
  localparam pc_t STEP_MOD      = 4'd3;
  localparam pc_t STEP_MOD_DONE = 4'd4;
  localparam pc_t STEP_LOOP     = 4'd5;
  localparam pc_t STEP_SETUP_A  = 4'd6;
  localparam pc_t STEP_MUL_A    = 4'd7;
  localparam pc_t STEP_STORE_A  = 4'd8;
  localparam pc_t STEP_SETUP_B  = 4'd9;
  localparam pc_t STEP_MUL_B    = 4'd10;
  localparam pc_t STEP_STORE_B  = 4'd11;
  localparam pc_t STEP_EMIT     = 4'd12;
  localparam pc_t STEP_RETURN   = 4'd13;

  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_LOAD      = 4'd1,
    OP_SET_ONE   = 4'd2,
    OP_CLR_ACC   = 4'd3,
    OP_MOD_STEP  = 4'd4,
    OP_MOD_DONE  = 4'd5,
    OP_SETUP_A   = 4'd6,
    OP_MUL_STEP  = 4'd7,
    OP_STORE_A   = 4'd8,
    OP_SETUP_B   = 4'd9,
    OP_STORE_B   = 4'd10,
    OP_EMIT      = 4'd11
  } op_t;

  typedef enum logic [3:0] {
    C_ALWAYS     = 4'd0,
    C_NO_INPUT   = 4'd1,
    C_EXP_ZERO   = 4'd2,
    C_MOD_ZERO   = 4'd3,
    C_CNT_MORE   = 4'd4,
    C_EBIT_CLEAR = 4'd5,
    C_MUL_MORE   = 4'd6,
    C_EXP_MORE   = 4'd7,
    C_OUT_BUSY   = 4'd8
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t cw;
    cw = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_IDLE};
    case (pc)
      STEP_IDLE:     cw = '{op: OP_LOAD,     cond: C_NO_INPUT,   target: STEP_IDLE};
      STEP_CHK_EXP:  cw = '{op: OP_SET_ONE,  cond: C_EXP_ZERO,   target: STEP_EMIT};
      STEP_CHK_MOD:  cw = '{op: OP_CLR_ACC,  cond: C_MOD_ZERO,   target: STEP_EMIT};
      STEP_MOD:      cw = '{op: OP_MOD_STEP, cond: C_CNT_MORE,   target: STEP_MOD};
      STEP_MOD_DONE: cw = '{op: OP_MOD_DONE, cond: C_ALWAYS,     target: STEP_LOOP};
      STEP_LOOP:     cw = '{op: OP_NOP,      cond: C_EBIT_CLEAR, target: STEP_SETUP_B};
      STEP_SETUP_A:  cw = '{op: OP_SETUP_A,  cond: C_ALWAYS,     target: STEP_MUL_A};
      STEP_MUL_A:    cw = '{op: OP_MUL_STEP, cond: C_MUL_MORE,   target: STEP_MUL_A};
      STEP_STORE_A:  cw = '{op: OP_STORE_A,  cond: C_ALWAYS,     target: STEP_SETUP_B};
      STEP_SETUP_B:  cw = '{op: OP_SETUP_B,  cond: C_ALWAYS,     target: STEP_MUL_B};
      STEP_MUL_B:    cw = '{op: OP_MUL_STEP, cond: C_MUL_MORE,   target: STEP_MUL_B};
      STEP_STORE_B:  cw = '{op: OP_STORE_B,  cond: C_EXP_MORE,   target: STEP_LOOP};
      STEP_EMIT:     cw = '{op: OP_EMIT,     cond: C_OUT_BUSY,   target: STEP_EMIT};
      STEP_RETURN:   cw = '{op: OP_NOP,      cond: C_ALWAYS,     target: STEP_IDLE};
      default:       cw = '{op: OP_NOP,      cond: C_ALWAYS,     target: STEP_IDLE};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/modular_exponentiation.sv =====
// Modular exponentiation, right-to-left square-and-multiply, microcoded control.
// The base is first reduced bit-serially; then for each exponent bit up to the top set bit
// the bit is tested, a multiply follows when the bit is set, and a square always follows;
// each multiply is shift-and-add over the bit length k of the multiplier.
// One item at a time; the next beat is taken once the result is in the output register.
// Reset: synchronous active-low, clears the step counter and the output valid.
// Depends on mexp_pkg and mexp_add_mod.
`default_nettype none

module modular_exponentiation #(
  parameter int WIDTH = 62
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [61:0] base_value, [123:62] exponent_value, [185:124] modulus_value
  input  wire logic [mexp_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [61:0] power_result
  output logic      [mexp_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int CNT_W = $clog2(WIDTH + 1);
  localparam int FW    = mexp_pkg::FIELD_W;

  mexp_pkg::pc_t   pc_r, pc_nxt;
  mexp_pkg::ctrl_t cw;
  logic            take;

  logic [WIDTH-1:0] m_r, m_nxt;
  logic [WIDTH-1:0] e_r, e_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] mx_r, mx_nxt;
  logic [WIDTH-1:0] my_r, my_nxt;
  logic [WIDTH-1:0] mp_r, mp_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_data_r, out_data_nxt;

  logic [WIDTH-1:0] sum_red;
  logic [WIDTH-1:0] dbl_red;
  logic [WIDTH:0]   rem_dbl;
  logic [WIDTH:0]   rem_sub;
  logic [WIDTH-1:0] rem_red;
  logic [WIDTH-1:0] acc_red;
  logic             out_busy;

  assign cw        = mexp_pkg::ucode(pc_r);
  assign out_busy  = out_valid_r && !out_tready;
  assign in_tready = (pc_r == mexp_pkg::STEP_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = mexp_pkg::OUT_TDATA_W'(out_data_r);

  mexp_add_mod #(.WIDTH(WIDTH)) u_add_acc (
    .x (mp_r),
    .y (mx_r),
    .m (m_r),
    .s (sum_red)
  );

  mexp_add_mod #(.WIDTH(WIDTH)) u_add_dbl (
    .x (mx_r),
    .y (mx_r),
    .m (m_r),
    .s (dbl_red)
  );

  always_comb begin
    rem_dbl = {rem_r, b_r[WIDTH-1]};
    rem_sub = rem_dbl - {1'b0, m_r};
    if (rem_dbl >= {1'b0, m_r}) begin
      rem_red = rem_sub[WIDTH-1:0];
    end else begin
      rem_red = rem_dbl[WIDTH-1:0];
    end
    if (a_r >= m_r) begin
      acc_red = a_r - m_r;
    end else begin
      acc_red = a_r;
    end
  end

  always_comb begin
    case (cw.cond)
      mexp_pkg::C_ALWAYS:     take = 1'b1;
      mexp_pkg::C_NO_INPUT:   take = !in_tvalid;
      mexp_pkg::C_EXP_ZERO:   take = (e_r == '0);
      mexp_pkg::C_MOD_ZERO:   take = (m_r == '0);
      mexp_pkg::C_CNT_MORE:   take = (cnt_r != CNT_W'(1));
      mexp_pkg::C_EBIT_CLEAR: take = !e_r[0];
      mexp_pkg::C_MUL_MORE:   take = (my_r[WIDTH-1:1] != '0);
      mexp_pkg::C_EXP_MORE:   take = (e_r[WIDTH-1:1] != '0);
      mexp_pkg::C_OUT_BUSY:   take = out_busy;
      default:                take = 1'b0;
    endcase
    if (take) begin
      pc_nxt = cw.target;
    end else begin
      pc_nxt = pc_r + mexp_pkg::PC_W'(1);
    end
  end

  always_comb begin
    m_nxt         = m_r;
    e_nxt         = e_r;
    b_nxt         = b_r;
    a_nxt         = a_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    mp_nxt        = mp_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (cw.op)
      mexp_pkg::OP_LOAD: begin
        if (in_tvalid) begin
          b_nxt   = in_tdata[WIDTH-1:0];
          e_nxt   = in_tdata[FW+WIDTH-1:FW];
          m_nxt   = in_tdata[2*FW+WIDTH-1:2*FW];
          rem_nxt = '0;
          cnt_nxt = CNT_W'(WIDTH);
        end
      end
      mexp_pkg::OP_SET_ONE: begin
        a_nxt = WIDTH'(1);
      end
      mexp_pkg::OP_CLR_ACC: begin
        a_nxt = '0;
      end
      mexp_pkg::OP_MOD_STEP: begin
        rem_nxt = rem_red;
        b_nxt   = {b_r[WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      mexp_pkg::OP_MOD_DONE: begin
        b_nxt = rem_r;
        a_nxt = WIDTH'(1);
      end
      mexp_pkg::OP_SETUP_A: begin
        mx_nxt = acc_red;
        my_nxt = b_r;
        mp_nxt = '0;
      end
      mexp_pkg::OP_MUL_STEP: begin
        if (my_r[0]) begin
          mp_nxt = sum_red;
        end
        mx_nxt = dbl_red;
        my_nxt = {1'b0, my_r[WIDTH-1:1]};
      end
      mexp_pkg::OP_STORE_A: begin
        a_nxt = mp_r;
      end
      mexp_pkg::OP_SETUP_B: begin
        mx_nxt = b_r;
        my_nxt = b_r;
        mp_nxt = '0;
      end
      mexp_pkg::OP_STORE_B: begin
        b_nxt = mp_r;
        e_nxt = {1'b0, e_r[WIDTH-1:1]};
      end
      mexp_pkg::OP_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = a_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= mexp_pkg::STEP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r        <= m_nxt;
    e_r        <= e_nxt;
    b_r        <= b_nxt;
    a_r        <= a_nxt;
    mx_r       <= mx_nxt;
    my_r       <= my_nxt;
    mp_r       <= mp_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/mexp_add_mod.sv =====
// Modular adder: (x + y) mod m for x, y < m, by one add and one conditional subtract.
// Self-contained; no package use.
`default_nettype none

module mexp_add_mod #(
  parameter int WIDTH = 62
) (
  input  wire logic [WIDTH-1:0] x,
  input  wire logic [WIDTH-1:0] y,
  input  wire logic [WIDTH-1:0] m,
  output logic      [WIDTH-1:0] s
);

  logic [WIDTH:0] sum;
  logic [WIDTH:0] diff;

  always_comb begin
    sum  = {1'b0, x} + {1'b0, y};
    diff = sum - {1'b0, m};
    if (sum >= {1'b0, m}) begin
      s = diff[WIDTH-1:0];
    end else begin
      s = sum[WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== tb/modular_exponentiation_tb.sv =====
// Self-checking testbench for modular_exponentiation: random and edge-case operand beats,
// random stalls on both streams, results checked in order against an internal power model.
// Depends on mexp_pkg and the modular_exponentiation RTL.
`default_nettype none

module modular_exponentiation_tb;

  localparam int FIELD_W     = mexp_pkg::FIELD_W;
  localparam int IN_TDATA_W  = mexp_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = mexp_pkg::OUT_TDATA_W;

  typedef logic [FIELD_W-1:0] operand_t;

  localparam operand_t OPERAND_MAX = '1;
  localparam operand_t PATTERN_A = {31{2'b10}};
  localparam operand_t PATTERN_B = {31{2'b01}};
  localparam int RANDOM_ITEMS = 100;
  localparam int ITEM_CYCLES = 8200;
  localparam int CYCLE_LIMIT = 4 * (RANDOM_ITEMS + 25) * (ITEM_CYCLES + 32);
  localparam int SETTLE_CYCLES = 64;
  localparam int REPORT_MAX = 10;

  class power_scoreboard;
    operand_t expected_powers[$];
    int failures;

    function new();
      failures = 0;
    endfunction

    function operand_t mod_power(operand_t b, operand_t e, operand_t m);
      logic [2*FIELD_W-1:0] prod;
      operand_t acc;
      operand_t sq;
      operand_t rest;
      if (e == '0) return operand_t'(1);
      if (m == '0) return '0;
      acc = operand_t'(1);
      sq = b % m;
      rest = e;
      while (rest != '0) begin
        if (rest[0]) begin
          prod = {{FIELD_W{1'b0}}, acc} * {{FIELD_W{1'b0}}, sq};
          acc = operand_t'(prod % {{FIELD_W{1'b0}}, m});
        end
        prod = {{FIELD_W{1'b0}}, sq} * {{FIELD_W{1'b0}}, sq};
        sq = operand_t'(prod % {{FIELD_W{1'b0}}, m});
        rest = rest >> 1;
      end
      return acc;
    endfunction

    function void note_operands(operand_t b, operand_t e, operand_t m);
      expected_powers.push_back(mod_power(b, e, m));
    endfunction

    function void check_power(operand_t got);
      operand_t want;
      if (expected_powers.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("result beat with nothing outstanding: power_result=%h", got);
        return;
      end
      want = expected_powers.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("power_result mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  power_scoreboard board;
  bit in_calm;
  int beats_sent;
  int cycle_count;

  modular_exponentiation #(.WIDTH(FIELD_W)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic operand_t rand_operand();
    int bits;
    operand_t v;
    bits = ($urandom_range(0, 3) == 0) ? FIELD_W : $urandom_range(1, FIELD_W);
    v = operand_t'({$urandom, $urandom});
    return v & ((operand_t'(1) << bits) - operand_t'(1));
  endfunction

  task automatic send_operands(input operand_t b, input operand_t e, input operand_t m);
    int gap;
    if (beats_sent % 8 == 0) in_calm = ($urandom_range(0, 3) == 0);
    gap = in_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W - 3 * FIELD_W){1'b0}}, m, e, b};
    do @(posedge clk); while (!in_tready);
    board.note_operands(b, e, m);
    beats_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_power(out_tdata[FIELD_W-1:0]);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int stall;
    int served;
    bit out_calm;
    served = 0;
    out_calm = 1'b0;
    out_tready <= 1'b0;
    forever begin
      if (served % 8 == 0) out_calm = ($urandom_range(0, 3) == 0);
      stall = out_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      served++;
    end
  end

  initial begin
    int kind;
    operand_t b;
    operand_t e;
    operand_t m;
    board = new();
    beats_sent = 0;
    in_calm = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_operands('0, '0, operand_t'(1));
    send_operands(OPERAND_MAX, '0, OPERAND_MAX);
    send_operands(PATTERN_A, '0, '0);
    send_operands('0, '0, '0);
    send_operands(operand_t'(5), operand_t'(3), operand_t'(1));
    send_operands(OPERAND_MAX, OPERAND_MAX, '0);
    send_operands('0, operand_t'(5), operand_t'(7));
    send_operands(OPERAND_MAX, OPERAND_MAX, OPERAND_MAX);
    send_operands(OPERAND_MAX, OPERAND_MAX, OPERAND_MAX - 1);
    send_operands(operand_t'(2), operand_t'(61), OPERAND_MAX);
    send_operands(OPERAND_MAX - 1, operand_t'(2), OPERAND_MAX);
    send_operands(operand_t'(3), operand_t'(1), OPERAND_MAX);
    send_operands(OPERAND_MAX, operand_t'(1), operand_t'(7));
    send_operands(PATTERN_A, PATTERN_B, PATTERN_B);
    send_operands(PATTERN_B, PATTERN_A, PATTERN_A);
    send_operands(operand_t'(1), OPERAND_MAX, operand_t'(2));
    send_operands(operand_t'(1) << 61, operand_t'(2), (operand_t'(1) << 61) + 1);
    send_operands(operand_t'(7), operand_t'(1), operand_t'(1));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 99);
      b = rand_operand();
      e = rand_operand();
      m = rand_operand();
      if (kind < 8) e = '0;
      else if (kind < 13) m = operand_t'(1);
      else if (kind < 15) m = '0;
      else if (m == '0) m = operand_t'(1);
      send_operands(b, e, m);
    end
    in_tvalid <= 1'b0;

    while (board.expected_powers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.failures == 0 && board.expected_powers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== modular_exponentiation.f =====
hdl/mexp_pkg.sv
hdl/mexp_add_mod.sv
hdl/modular_exponentiation.sv
tb/modular_exponentiation_tb.sv
